// File: rtl/avr_pkg.sv
// ----------------------------------------------------------------------------
// avr_pkg
// Shared widths, payload types and CORDIC constants for the axis-angle
// vector rotation pipeline.
// ----------------------------------------------------------------------------
package avr_pkg;

    // Vector component width (input and output)
    localparam int CW           = 16;
    // Axis and sine/cosine width, Q1.14
    localparam int AX_W         = 16;
    localparam int ANG_W        = 16;

    // CORDIC datapath, Q2.30 with headroom
    localparam int CORDIC_STEPS = 16;
    localparam int CORD_W       = 34;
    localparam logic signed [CORD_W-1:0] CORDIC_ONE = 34'sd652032874;

    // Matrix build widths
    localparam int AXP_W        = 2 * AX_W;        // a_i * a_j
    localparam int M_W          = AXP_W + 2;       // a_i*a_j - d*|a|^2
    localparam int OMC_W        = AX_W + 1;        // 1 - cos, Q2.14
    localparam int PM_W         = OMC_W + M_W;     // omc * m
    localparam int Q_W          = PM_W + 3;        // matrix entry, Q42
    localparam int R_SHIFT      = 18;
    localparam int R_W          = 36;              // matrix entry, Q24

    // Matrix-vector product widths
    localparam int P_W          = R_W + CW;
    localparam int ACC_W        = P_W + 2;
    localparam int OUT_SHIFT    = 24;

    // Register stages from accept to result register
    localparam int PIPE_DEPTH   = CORDIC_STEPS + 6;

    // Arctangent of 2^-i in units of 2^-32 turn
    localparam logic signed [CORD_W-1:0] ATAN_LUT [CORDIC_STEPS] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861
    };

    typedef struct packed {
        logic signed [CW-1:0]   vec_x;
        logic signed [CW-1:0]   vec_y;
        logic signed [CW-1:0]   vec_z;
        logic signed [AX_W-1:0] axis_x;
        logic signed [AX_W-1:0] axis_y;
        logic signed [AX_W-1:0] axis_z;
        logic [ANG_W-1:0]       angle;
    } avr_in_t;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
    } avr_out_t;

    // CORDIC result with the item's vector and axis
    typedef struct packed {
        logic signed [CORD_W-1:0] cx;
        logic signed [CORD_W-1:0] sy;
        logic                     flip;
        avr_in_t                  item;
    } avr_trig_t;

    // Rotation matrix, row-major, Q24, with the vector
    typedef struct packed {
        logic [8:0][R_W-1:0]  r;
        logic signed [CW-1:0] vx;
        logic signed [CW-1:0] vy;
        logic signed [CW-1:0] vz;
    } avr_rot_t;

    // Pipeline control shared by all stages
    typedef struct packed {
        logic en;
    } avr_ctl_t;

endpackage

// File: rtl/axis_angle_vector_rotate.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate
// Register stages from accepted transaction to result valid: 16 CORDIC
// stages, 4 matrix stages, product stage, result register.
// Throughput: one transaction per cycle; the whole pipeline holds while the
// result register is full and not taken.
// Reset: valid bits clear asynchronously; payload registers are not reset.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotate
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  avr_pkg::avr_in_t   item,
    output logic               result_valid,
    input  logic               result_ready,
    output avr_pkg::avr_out_t  result
);
    import avr_pkg::*;

    avr_ctl_t  ctl;
    logic      trig_valid, rot_valid;
    avr_trig_t trig;
    avr_rot_t  rot;

    // Advance every stage unless the result register is full and held
    assign ctl.en     = !result_valid || result_ready;
    assign item_ready = ctl.en;

    avr_cordic u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .in_valid  (item_valid),
        .in_item   (item),
        .out_valid (trig_valid),
        .out_trig  (trig)
    );

    avr_matrix u_matrix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .in_valid  (trig_valid),
        .in_trig   (trig),
        .out_valid (rot_valid),
        .out_rot   (rot)
    );

    avr_apply u_apply
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .in_valid   (rot_valid),
        .in_rot     (rot),
        .out_valid  (result_valid),
        .out_result (result)
    );

endmodule

// File: rtl/avr_cordic.sv
// ----------------------------------------------------------------------------
// avr_cordic
// Sixteen-stage CORDIC in rotation mode, one iteration per register stage.
// Carries the item's vector and axis alongside.
// ----------------------------------------------------------------------------
module avr_cordic
(
    input  logic                clk,
    input  logic                rst_n,
    input  avr_pkg::avr_ctl_t   ctl,
    input  logic                in_valid,
    input  avr_pkg::avr_in_t    in_item,
    output logic                out_valid,
    output avr_pkg::avr_trig_t  out_trig
);
    import avr_pkg::*;

    logic signed [CORD_W-1:0] x_reg [CORDIC_STEPS];
    logic signed [CORD_W-1:0] y_reg [CORDIC_STEPS];
    logic signed [CORD_W-1:0] z_reg [CORDIC_STEPS];
    logic                     flip_reg [CORDIC_STEPS];
    avr_in_t                  item_reg [CORDIC_STEPS];
    logic                     valid_reg [CORDIC_STEPS];

    logic signed [CORD_W-1:0] z_fold;
    logic                     flip_in;

    // Fold the angle into +-quarter turn; a half-turn shift flips the top bit
    always_comb
    begin
        z_fold  = CORD_W'($signed({~in_item.angle[ANG_W-1], in_item.angle[ANG_W-2:0],
                                    16'b0}));
        flip_in = (in_item.angle > 16'h4000) && (in_item.angle < 16'hC000);
        if (!flip_in)
        begin
            z_fold = CORD_W'($signed({in_item.angle, 16'b0}));
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_stage
        logic signed [CORD_W-1:0] x_in, y_in, z_in;
        logic signed [CORD_W-1:0] x_next, y_next, z_next;
        logic                     flip_in_k, valid_in_k;
        avr_in_t                  item_in_k;

        if (k == 0)
        begin : g_first
            assign x_in       = CORDIC_ONE;
            assign y_in       = '0;
            assign z_in       = z_fold;
            assign flip_in_k  = flip_in;
            assign item_in_k  = in_item;
            assign valid_in_k = in_valid;
        end
        else
        begin : g_rest
            assign x_in       = x_reg[k-1];
            assign y_in       = y_reg[k-1];
            assign z_in       = z_reg[k-1];
            assign flip_in_k  = flip_reg[k-1];
            assign item_in_k  = item_reg[k-1];
            assign valid_in_k = valid_reg[k-1];
        end

        // Rotate toward zero residual angle
        always_comb
        begin
            if (z_in >= 0)
            begin
                x_next = x_in - (y_in >>> k);
                y_next = y_in + (x_in >>> k);
                z_next = z_in - ATAN_LUT[k];
            end
            else
            begin
                x_next = x_in + (y_in >>> k);
                y_next = y_in - (x_in >>> k);
                z_next = z_in + ATAN_LUT[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (ctl.en)
            begin
                valid_reg[k] <= valid_in_k;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                x_reg[k]    <= x_next;
                y_reg[k]    <= y_next;
                z_reg[k]    <= z_next;
                flip_reg[k] <= flip_in_k;
                item_reg[k] <= item_in_k;
            end
        end
    end

    assign out_valid     = valid_reg[CORDIC_STEPS-1];
    assign out_trig.cx   = x_reg[CORDIC_STEPS-1];
    assign out_trig.sy   = y_reg[CORDIC_STEPS-1];
    assign out_trig.flip = flip_reg[CORDIC_STEPS-1];
    assign out_trig.item = item_reg[CORDIC_STEPS-1];

endmodule

// File: rtl/avr_matrix.sv
// ----------------------------------------------------------------------------
// avr_matrix
// Builds the Rodrigues rotation matrix in four register stages:
// trig rounding and axis products, axis terms, omc products, entries.
// ----------------------------------------------------------------------------
module avr_matrix
(
    input  logic                clk,
    input  logic                rst_n,
    input  avr_pkg::avr_ctl_t   ctl,
    input  logic                in_valid,
    input  avr_pkg::avr_trig_t  in_trig,
    output logic                out_valid,
    output avr_pkg::avr_rot_t   out_rot
);
    import avr_pkg::*;

    localparam logic signed [Q_W-1:0] DIAG_ONE = Q_W'(64'sd1 <<< 42);
    localparam logic signed [Q_W-1:0] R_HALF   = Q_W'(64'sd1 <<< (R_SHIFT - 1));

    // Stage 1 registers
    logic                     s1_valid_reg;
    logic signed [AX_W-1:0]   s1_sin_reg;
    logic signed [OMC_W-1:0]  s1_omc_reg;
    logic signed [AXP_W-1:0]  s1_xx_reg, s1_yy_reg, s1_zz_reg;
    logic signed [AXP_W-1:0]  s1_xy_reg, s1_xz_reg, s1_yz_reg;
    avr_in_t                  s1_item_reg;
    // Stage 2 registers
    logic                     s2_valid_reg;
    logic signed [OMC_W-1:0]  s2_omc_reg;
    logic signed [M_W-1:0]    s2_mxx_reg, s2_myy_reg, s2_mzz_reg;
    logic signed [M_W-1:0]    s2_mxy_reg, s2_mxz_reg, s2_myz_reg;
    logic signed [AXP_W-1:0]  s2_sax_reg, s2_say_reg, s2_saz_reg;
    avr_in_t                  s2_item_reg;
    // Stage 3 registers
    logic                     s3_valid_reg;
    logic signed [PM_W-1:0]   s3_pxx_reg, s3_pyy_reg, s3_pzz_reg;
    logic signed [PM_W-1:0]   s3_pxy_reg, s3_pxz_reg, s3_pyz_reg;
    logic signed [AXP_W-1:0]  s3_sax_reg, s3_say_reg, s3_saz_reg;
    avr_in_t                  s3_item_reg;
    // Stage 4 registers
    logic                     s4_valid_reg;
    avr_rot_t                 s4_rot_reg;

    logic signed [CORD_W-1:0] c_rnd, s_rnd;
    logic signed [AX_W-1:0]   c_sat, s_sat, c_next, s_next;
    logic signed [Q_W-1:0]    q [9];
    logic signed [Q_W-1:0]    sw_x, sw_y, sw_z;
    avr_rot_t                 rot_next;

    // Round Q2.30 to Q1.14, clamp to +-1.0, undo the fold
    always_comb
    begin
        c_rnd = (in_trig.cx + 34'sd32768) >>> 16;
        s_rnd = (in_trig.sy + 34'sd32768) >>> 16;
        priority if (c_rnd > 34'sd16384)
            c_sat = 16'sd16384;
        else if (c_rnd < -34'sd16384)
            c_sat = -16'sd16384;
        else
            c_sat = c_rnd[AX_W-1:0];
        priority if (s_rnd > 34'sd16384)
            s_sat = 16'sd16384;
        else if (s_rnd < -34'sd16384)
            s_sat = -16'sd16384;
        else
            s_sat = s_rnd[AX_W-1:0];
        c_next = in_trig.flip ? -c_sat : c_sat;
        s_next = in_trig.flip ? -s_sat : s_sat;
    end

    // Assemble entries: identity + sin*W*2^14 + omc*(a*a' - I*|a|^2)
    always_comb
    begin
        sw_x = Q_W'(s3_sax_reg) <<< 14;
        sw_y = Q_W'(s3_say_reg) <<< 14;
        sw_z = Q_W'(s3_saz_reg) <<< 14;
        q[0] = DIAG_ONE + Q_W'(s3_pxx_reg);
        q[1] = Q_W'(s3_pxy_reg) - sw_z;
        q[2] = Q_W'(s3_pxz_reg) + sw_y;
        q[3] = Q_W'(s3_pxy_reg) + sw_z;
        q[4] = DIAG_ONE + Q_W'(s3_pyy_reg);
        q[5] = Q_W'(s3_pyz_reg) - sw_x;
        q[6] = Q_W'(s3_pxz_reg) - sw_y;
        q[7] = Q_W'(s3_pyz_reg) + sw_x;
        q[8] = DIAG_ONE + Q_W'(s3_pzz_reg);
        for (int i = 0; i < 9; i++)
        begin
            rot_next.r[i] = R_W'((q[i] + R_HALF) >>> R_SHIFT);
        end
        rot_next.vx = s3_item_reg.vec_x;
        rot_next.vy = s3_item_reg.vec_y;
        rot_next.vz = s3_item_reg.vec_z;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            s1_sin_reg  <= s_next;
            s1_omc_reg  <= OMC_W'(17'sd16384 - OMC_W'(c_next));
            s1_xx_reg   <= in_trig.item.axis_x * in_trig.item.axis_x;
            s1_yy_reg   <= in_trig.item.axis_y * in_trig.item.axis_y;
            s1_zz_reg   <= in_trig.item.axis_z * in_trig.item.axis_z;
            s1_xy_reg   <= in_trig.item.axis_x * in_trig.item.axis_y;
            s1_xz_reg   <= in_trig.item.axis_x * in_trig.item.axis_z;
            s1_yz_reg   <= in_trig.item.axis_y * in_trig.item.axis_z;
            s1_item_reg <= in_trig.item;

            s2_omc_reg  <= s1_omc_reg;
            s2_mxx_reg  <= -(M_W'(s1_yy_reg) + M_W'(s1_zz_reg));
            s2_myy_reg  <= -(M_W'(s1_xx_reg) + M_W'(s1_zz_reg));
            s2_mzz_reg  <= -(M_W'(s1_xx_reg) + M_W'(s1_yy_reg));
            s2_mxy_reg  <= M_W'(s1_xy_reg);
            s2_mxz_reg  <= M_W'(s1_xz_reg);
            s2_myz_reg  <= M_W'(s1_yz_reg);
            s2_sax_reg  <= s1_sin_reg * s1_item_reg.axis_x;
            s2_say_reg  <= s1_sin_reg * s1_item_reg.axis_y;
            s2_saz_reg  <= s1_sin_reg * s1_item_reg.axis_z;
            s2_item_reg <= s1_item_reg;

            s3_pxx_reg  <= PM_W'(s2_omc_reg) * PM_W'(s2_mxx_reg);
            s3_pyy_reg  <= PM_W'(s2_omc_reg) * PM_W'(s2_myy_reg);
            s3_pzz_reg  <= PM_W'(s2_omc_reg) * PM_W'(s2_mzz_reg);
            s3_pxy_reg  <= PM_W'(s2_omc_reg) * PM_W'(s2_mxy_reg);
            s3_pxz_reg  <= PM_W'(s2_omc_reg) * PM_W'(s2_mxz_reg);
            s3_pyz_reg  <= PM_W'(s2_omc_reg) * PM_W'(s2_myz_reg);
            s3_sax_reg  <= s2_sax_reg;
            s3_say_reg  <= s2_say_reg;
            s3_saz_reg  <= s2_saz_reg;
            s3_item_reg <= s2_item_reg;

            s4_rot_reg  <= rot_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_rot   = s4_rot_reg;

endmodule

// File: rtl/avr_apply.sv
// ----------------------------------------------------------------------------
// avr_apply
// Multiplies the rotation matrix by the vector, then sums, rounds and
// saturates each row into the result register.
// ----------------------------------------------------------------------------
module avr_apply
(
    input  logic               clk,
    input  logic               rst_n,
    input  avr_pkg::avr_ctl_t  ctl,
    input  logic               in_valid,
    input  avr_pkg::avr_rot_t  in_rot,
    output logic               out_valid,
    output avr_pkg::avr_out_t  out_result
);
    import avr_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        $signed({{(ACC_W-CW+1){1'b0}}, {(CW-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(64'sd1 <<< (OUT_SHIFT - 1));

    logic                    p_valid_reg;
    logic signed [P_W-1:0]   p_reg [9];
    logic                    o_valid_reg;
    avr_out_t                o_result_reg;

    logic signed [CW-1:0]    v [3];
    logic signed [ACC_W-1:0] acc [3];
    logic signed [ACC_W-1:0] rnd [3];
    logic signed [CW-1:0]    sat [3];
    avr_out_t                result_next;

    assign v[0] = in_rot.vx;
    assign v[1] = in_rot.vy;
    assign v[2] = in_rot.vz;

    // Sum each row, round half up, saturate
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = ACC_W'(p_reg[3*i]) + ACC_W'(p_reg[3*i+1]) + ACC_W'(p_reg[3*i+2]);
            rnd[i] = (acc[i] + ACC_HALF) >>> OUT_SHIFT;
            priority if (rnd[i] > SAT_HI)
                sat[i] = SAT_HI[CW-1:0];
            else if (rnd[i] < SAT_LO)
                sat[i] = SAT_LO[CW-1:0];
            else
                sat[i] = rnd[i][CW-1:0];
        end
        result_next.out_x = sat[0];
        result_next.out_y = sat[1];
        result_next.out_z = sat[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            p_valid_reg <= in_valid;
            o_valid_reg <= p_valid_reg;
        end
    end

    // Hold products and result while stalled
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                p_reg[i] <= P_W'($signed(in_rot.r[i])) * P_W'(v[i % 3]);
            end
            o_result_reg <= result_next;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_result = o_result_reg;

endmodule

// File: rtl/avr_checker.sv
// ----------------------------------------------------------------------------
// avr_checker
// Port-level checks for the rotation pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module avr_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input avr_pkg::avr_in_t   item,
    input logic               result_valid,
    input logic               result_ready,
    input avr_pkg::avr_out_t  result
);
    import avr_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

    logic [CNT_W-1:0] inflight_reg, inflight_next;
    logic             in_acc, out_acc;

    assign in_acc  = item_valid && item_ready;
    assign out_acc = result_valid && result_ready;

    // Track transactions accepted but not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc)
            inflight_next = inflight_reg + 1'b1;
        else if (out_acc && !in_acc)
            inflight_next = inflight_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready == (!result_valid || result_ready))
        else $error("input stalled while output free");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> inflight_reg != '0)
        else $error("result without accepted transaction");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more transactions in flight than stages");

    a_item_known: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid |-> !$isunknown(item))
        else $error("unknown payload on offered transaction");

endmodule

bind axis_angle_vector_rotate avr_checker u_avr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

// File: bench/axis_angle_vector_rotate_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate_tb
// Sends vector/axis/angle transactions through the rotation pipeline and
// compares each rotated vector against a bit-exact fixed-point predictor
// (CORDIC sine/cosine, Rodrigues matrix, rounded and saturated product).
// ----------------------------------------------------------------------------
module axis_angle_vector_rotate_tb;
    import avr_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    avr_in_t   item;
    logic      result_valid;
    logic      result_ready;
    avr_out_t  result;

    avr_out_t  rotated_q[$];
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_off_cycles;
    int        mismatch_count;
    int        sent_count;
    int        rcvd_count;

    axis_angle_vector_rotate uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_sh(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Rotate one vector about its axis, fixed point, rounded and saturated
    function automatic avr_out_t predict_rotation(avr_in_t t);
        longint z, x, y, dx, dy, c, s, omc, n2, d, q, acc;
        longint v[3];
        longint a[3];
        longint w[9];
        longint r[9];
        longint res[3];
        bit     flip;
        avr_out_t o;
        z = longint'({t.angle, 16'h0000});
        x = CORDIC_ONE;
        y = 0;
        flip = 1'b0;
        if (z >= 64'sd2147483648)
            z -= 64'sd4294967296;
        if (z > 64'sd1073741824)
        begin
            z -= 64'sd2147483648;
            flip = 1'b1;
        end
        else if (z < -64'sd1073741824)
        begin
            z += 64'sd2147483648;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(ATAN_LUT[i]);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(ATAN_LUT[i]);
            end
        end
        c = clamp(round_sh(x, 16), -16384, 16384);
        s = clamp(round_sh(y, 16), -16384, 16384);
        if (flip)
        begin
            c = -c;
            s = -s;
        end
        omc = 16384 - c;
        v[0] = t.vec_x;
        v[1] = t.vec_y;
        v[2] = t.vec_z;
        a[0] = t.axis_x;
        a[1] = t.axis_y;
        a[2] = t.axis_z;
        w = '{0, -a[2], a[1], a[2], 0, -a[0], -a[1], a[0], 0};
        n2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                d = (i == j) ? 1 : 0;
                q = d * (longint'(1) <<< 42) + s * w[i * 3 + j] * 16384
                    + omc * (a[i] * a[j] - d * n2);
                r[i * 3 + j] = round_sh(q, 18);
            end
        for (int i = 0; i < 3; i++)
        begin
            acc = r[i * 3] * v[0] + r[i * 3 + 1] * v[1] + r[i * 3 + 2] * v[2];
            res[i] = clamp(round_sh(acc, 24), -32768, 32767);
        end
        o.out_x = res[0][15:0];
        o.out_y = res[1][15:0];
        o.out_z = res[2][15:0];
        return o;
    endfunction

    // Offer one transaction, predict it, hold until accepted
    task automatic send_item(avr_in_t t);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= t;
        rotated_q.push_back(predict_rotation(t));
        do
            @(posedge clk);
        while (!item_ready);
        sent_count++;
    endtask

    task automatic send_fields(int vx, int vy, int vz, int ax, int ay, int az, int ang);
        avr_in_t t;
        t.vec_x  = vx[15:0];
        t.vec_y  = vy[15:0];
        t.vec_z  = vz[15:0];
        t.axis_x = ax[15:0];
        t.axis_y = ay[15:0];
        t.axis_z = az[15:0];
        t.angle  = ang[15:0];
        send_item(t);
    endtask

    function automatic int rand_axis_comp();
        return $urandom_range(32768, 0) - 16384;
    endfunction

    // Extremes, zero axis, non-unit axis, special angles
    task automatic test_directed();
        send_fields(1000, 0, 0, 0, 0, 16384, 16384);
        send_fields(1000, 2000, 3000, 16384, 0, 0, 32768);
        send_fields(-32768, -32768, -32768, 0, 16384, 0, 0);
        send_fields(32767, 32767, 32767, -16384, 0, 0, 65535);
        send_fields(32767, -32768, 12345, 0, 0, 0, 12345);
        send_fields(32767, 32767, 32767, 32767, 32767, 32767, 8192);
        send_fields(-32768, 32767, -32768, -32768, -32768, -32768, 49152);
        send_fields(100, -200, 300, 9459, 9459, 9459, 21845);
        send_fields(-1, 1, 0, 0, 0, -16384, 16383);
        send_fields(32767, 0, 0, 0, 0, 16384, 16385);
        send_fields(0, 32767, 0, 11585, 11585, 0, 49151);
        send_fields(0, 0, 0, 16384, 16384, 16384, 30000);
        send_fields(-32768, 0, 32767, 0, -16384, 0, 1);
        send_fields(5, 5, 5, 32767, -32768, 0, 32767);
    endtask

    // Random transactions: mostly axis components within +-1.0, some arbitrary
    task automatic test_random(int count);
        avr_in_t t;
        for (int n = 0; n < count; n++)
        begin
            t = avr_in_t'($bits(avr_in_t)'({$urandom, $urandom, $urandom, $urandom}));
            if ($urandom_range(3, 0) != 0)
            begin
                t.axis_x = 16'(rand_axis_comp());
                t.axis_y = 16'(rand_axis_comp());
                t.axis_z = 16'(rand_axis_comp());
            end
            if ($urandom_range(7, 0) == 0)
                t.vec_x = $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
            send_item(t);
        end
    endtask

    // Drop the input and wait for every outstanding result
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (rotated_q.size() != 0)
            @(posedge clk);
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall
    task automatic test_backpressure();
        hold_off_cycles = 80;
        test_random(60);
        wait_drained();
    endtask

    // Receiver ready and long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            result_ready    <= 1'b0;
        end
        else
            result_ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
    end

    // Check each transaction taken from the result channel
    always @(posedge clk)
    begin
        avr_out_t exp_r;
        if (rst_n && result_valid && result_ready)
        begin
            rcvd_count++;
            if (rotated_q.size() == 0)
            begin
                $error("unexpected result %h", result);
                mismatch_count++;
            end
            else
            begin
                exp_r = rotated_q.pop_front();
                if (result.out_x !== exp_r.out_x)
                begin
                    $error("out_x expected %0d actual %0d", exp_r.out_x, result.out_x);
                    mismatch_count++;
                end
                if (result.out_y !== exp_r.out_y)
                begin
                    $error("out_y expected %0d actual %0d", exp_r.out_y, result.out_y);
                    mismatch_count++;
                end
                if (result.out_z !== exp_r.out_z)
                begin
                    $error("out_z expected %0d actual %0d", exp_r.out_z, result.out_z);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        item_valid      = 1'b0;
        item            = '0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_off_cycles = 0;
        mismatch_count  = 0;
        sent_count      = 0;
        rcvd_count      = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        send_idle_pct = 30;
        recv_idle_pct = 53;
        test_random(420);
        send_idle_pct = 53;
        recv_idle_pct = 30;
        test_random(420);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(400);
        test_backpressure();

        wait_drained();
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (rotated_q.size() != 0)
            mismatch_count++;
        $display("Sent %0d rotations (directed, random, back-pressure), checked %0d.",
                 sent_count, rcvd_count);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
